@@ rtl/tsrl_pkg.sv @@
package tsrl_pkg;

  localparam int TABLE_ENTRIES_DEF      = 16;
  localparam int TIME_FRACTION_BITS_DEF = 4;

  // Quotient bits produced by the ramp divider; the ramp offset never exceeds 16 bits.
  localparam int DIV_STEPS  = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic              op;
    logic [3:0]        entry_index;
    logic              entry_valid;
    logic [10:0]       start_minute;
    logic              ramped;
    logic signed [15:0] start_temp;
    logic signed [15:0] end_temp;
    logic [10:0]       ramp_minutes;
    logic [14:0]       now_time;
  } in_t;

  typedef struct packed {
    logic              found;
    logic signed [15:0] temperature;
  } out_t;

  // One stored schedule entry; the valid bit lives apart in flip-flops.
  typedef struct packed {
    logic [10:0]       start_minute;
    logic              ramped;
    logic signed [15:0] start_temp;
    logic signed [15:0] end_temp;
    logic [10:0]       ramp_minutes;
  } entry_t;

  typedef struct packed {
    logic wr_entry;
    logic start_query;
    logic scan_step;
    logic eval;
    logic mul;
    logic div_step;
    logic finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic simple;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/timed_setpoint_ramp_lookup.sv @@
// Daily setpoint schedule with linear ramps. A write request (op = write) stores one
// schedule entry in the slot given by entry_index; it yields no result, and a slot
// at or beyond TABLE_ENTRIES is dropped. A query request (op = query) gives the
// time of day in units of 2^-TIME_FRACTION_BITS minute and yields exactly one
// result: the entry with the latest start minute not after the query minute
// (lowest slot on a tie), its fixed temperature, or its ramp value interpolated
// and truncated toward zero, or found = 0 with temperature 0 when nothing applies.
// Requests are taken one at a time. A query walks the table one slot per cycle
// through the entry memory's single read port; a ramp still in progress also goes
// through a 16-step restoring divider. The result sits in an output register, so
// the next request is taken while it waits.
// All entries read as invalid after reset; no clearing pass is needed.
module timed_setpoint_ramp_lookup
  import tsrl_pkg::*;
#(
  parameter int TABLE_ENTRIES      = TABLE_ENTRIES_DEF,
  parameter int TIME_FRACTION_BITS = TIME_FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t cmd;
  sts_t sts;

  // Sequence the scan, ramp evaluation, divide and result hand-off
  tsrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the table, best-match search, multiplier, divider and output register
  tsrl_dp #(
    .TABLE_ENTRIES      (TABLE_ENTRIES),
    .TIME_FRACTION_BITS (TIME_FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ rtl/tsrl_ctrl.sv @@
module tsrl_ctrl
  import tsrl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_op,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_DRAIN = 8'b0000_0100,
    S_EVAL  = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_WRITE) begin
          cmd.wr_entry = 1'b1;
        end else if (accept && in_op == OP_QUERY) begin
          cmd.start_query = 1'b1;
          state_nxt       = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.simple ? S_DONE : S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

@@ rtl/tsrl_dp.sv @@
module tsrl_dp
  import tsrl_pkg::*;
#(
  parameter int TABLE_ENTRIES      = TABLE_ENTRIES_DEF,
  parameter int TIME_FRACTION_BITS = TIME_FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  in_t  in_data,
  input  cmd_t cmd,
  output sts_t sts,
  input  logic out_ready,
  output logic out_valid,
  output out_t out_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Table storage
  entry_t                   table_mem_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_r;
  logic [8:0]               wr_ext;
  logic [IDX_W-1:0]         wr_addr;
  logic                     wr_hit;
  entry_t                   wr_entry;

  // Scan
  logic [IDX_W-1:0] cnt_r;
  logic [14:0]      now_r;
  entry_t           rd_r;
  logic             rdv_r;
  logic             cmp_en_r;
  logic             have_r;
  entry_t           best_r;
  logic [14:0]      minute;
  logic             cand;

  // Evaluation
  logic [19:0]        sm_sh, now_ext, elapsed20, span20;
  logic               finished;
  logic signed [16:0] delta;
  logic [16:0]        absd17;
  logic [15:0]        absd_r;
  logic               neg_r;
  logic [14:0]        elapsed_r;
  logic [18:0]        span_r;
  logic [30:0]        prod;

  // Divider
  logic [18:0]          rem_r;
  logic [15:0]          q_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [19:0]          trial;
  logic                 ge;
  logic [19:0]          diff;
  logic [16:0]          qs;
  logic [16:0]          sum;

  // Result
  logic               res_found_r;
  logic signed [15:0] res_temp_r;
  logic               out_valid_r;
  out_t               out_data_r;

  assign wr_ext  = {5'd0, in_data.entry_index};
  assign wr_addr = wr_ext[IDX_W-1:0];
  assign wr_hit  = cmd.wr_entry && (wr_ext < 9'(TABLE_ENTRIES));

  assign wr_entry.start_minute = in_data.start_minute;
  assign wr_entry.ramped       = in_data.ramped;
  assign wr_entry.start_temp   = in_data.start_temp;
  assign wr_entry.end_temp     = in_data.end_temp;
  assign wr_entry.ramp_minutes = in_data.ramp_minutes;

  always_ff @(posedge clk) begin
    if (wr_hit) table_mem_r[wr_addr] <= wr_entry;
    rd_r <= table_mem_r[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_hit) begin
      vld_r[wr_addr] <= in_data.entry_valid;
    end
  end

  // Candidate: valid, not after the query minute, strictly later than the best so far
  assign minute = now_r >> TIME_FRACTION_BITS;
  assign cand   = cmp_en_r && rdv_r && ({4'd0, rd_r.start_minute} <= minute) &&
                  (!have_r || rd_r.start_minute > best_r.start_minute);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_en_r <= 1'b0;
      have_r   <= 1'b0;
    end else begin
      cmp_en_r <= cmd.scan_step;
      if (cmd.start_query) have_r <= 1'b0;
      else if (cand)       have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdv_r <= vld_r[cnt_r];
    if (cmd.start_query) begin
      cnt_r <= '0;
      now_r <= in_data.now_time;
    end else if (cmd.scan_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cand) best_r <= rd_r;
  end

  assign sm_sh     = 20'(best_r.start_minute) << TIME_FRACTION_BITS;
  assign now_ext   = 20'(now_r);
  assign elapsed20 = now_ext - sm_sh;
  assign span20    = 20'(best_r.ramp_minutes) << TIME_FRACTION_BITS;
  assign finished  = (elapsed20 >= span20);

  assign delta  = {best_r.end_temp[15], best_r.end_temp} -
                  {best_r.start_temp[15], best_r.start_temp};
  assign absd17 = delta[16] ? (17'd0 - delta) : delta;
  assign prod   = {15'd0, absd_r} * {16'd0, elapsed_r};

  assign trial = {rem_r, q_r[15]};
  assign ge    = (trial >= {1'b0, span_r});
  assign diff  = trial - {1'b0, span_r};

  assign qs  = neg_r ? (17'd0 - {1'b0, q_r}) : {1'b0, q_r};
  assign sum = {best_r.start_temp[15], best_r.start_temp} + qs;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_found_r <= have_r;
      res_temp_r  <= have_r ? best_r.end_temp : 16'sd0;
      absd_r      <= absd17[15:0];
      neg_r       <= delta[16];
      elapsed_r   <= elapsed20[14:0];
      span_r      <= span20[18:0];
    end
    if (cmd.mul) begin
      rem_r     <= {4'd0, prod[30:16]};
      q_r       <= prod[15:0];
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= ge ? diff[18:0] : trial[18:0];
      q_r       <= {q_r[14:0], ge};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.finish) res_temp_r <= sum[15:0];
    if (cmd.load_out) begin
      out_data_r.found       <= res_found_r;
      out_data_r.temperature <= res_temp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)             out_valid_r <= 1'b0;
    else if (cmd.load_out)  out_valid_r <= 1'b1;
    else if (out_ready)     out_valid_r <= 1'b0;
  end

  assign sts.scan_last = (cnt_r == IDX_W'(TABLE_ENTRIES - 1));
  assign sts.simple    = !have_r || !best_r.ramped || (best_r.ramp_minutes == 11'd0) ||
                         finished;
  assign sts.div_last  = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/tsrl_chk.sv @@
module tsrl_chk
  import tsrl_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // A miss always reports zero temperature
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.temperature == 16'sd0)
    else $error("not-found result with nonzero temperature");

  // A query keeps the input closed while it runs
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == OP_QUERY |=> !in_ready)
    else $error("request accepted right after a query");

  // A write leaves the input open for the next request
  a_write_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == OP_WRITE |=> in_ready)
    else $error("write request stalled the input");

endmodule

bind timed_setpoint_ramp_lookup tsrl_chk u_tsrl_chk (.*);

@@ verif/timed_setpoint_ramp_lookup_tb.sv @@
module timed_setpoint_ramp_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsrl_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  // Quiet tail to watch for stray results; padded past the longest query.
  localparam int QUIET_CYCLES = 64;
  localparam int RANDOM_COUNT = 1130;

  // Keep a shadow copy of the schedule table and predict each query answer.
  class setpoint_scoreboard;
    entry_t slot [TABLE_ENTRIES_DEF];
    bit     slot_on [TABLE_ENTRIES_DEF];
    out_t   expected_q [$];
    int     errors;

    function new();
      foreach (slot[i]) begin
        slot[i]    = '0;
        slot_on[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function out_t lookup(logic [14:0] now);
      int     best;
      int     minute;
      longint elapsed;
      longint span;
      longint st;
      longint et;
      longint value;
      out_t   res;
      best   = -1;
      minute = int'(now) >> TIME_FRACTION_BITS_DEF;
      for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
        if (slot_on[i] && int'(slot[i].start_minute) <= minute) begin
          if (best < 0 || slot[i].start_minute > slot[best].start_minute) best = i;
        end
      end
      res = '0;
      if (best >= 0) begin
        st = $signed(slot[best].start_temp);
        et = $signed(slot[best].end_temp);
        value = et;
        if (slot[best].ramped && slot[best].ramp_minutes != 0) begin
          elapsed = longint'(now) -
                    (longint'(slot[best].start_minute) << TIME_FRACTION_BITS_DEF);
          span    = longint'(slot[best].ramp_minutes) << TIME_FRACTION_BITS_DEF;
          if (elapsed < span) value = st + ((et - st) * elapsed) / span;
        end
        res.found       = 1'b1;
        res.temperature = value[15:0];
      end
      return res;
    endfunction

    function void note_request(in_t req);
      if (req.op == OP_WRITE) begin
        if (int'(req.entry_index) < TABLE_ENTRIES_DEF) begin
          slot_on[req.entry_index]           = req.entry_valid;
          slot[req.entry_index].start_minute = req.start_minute;
          slot[req.entry_index].ramped       = req.ramped;
          slot[req.entry_index].start_temp   = req.start_temp;
          slot[req.entry_index].end_temp     = req.end_temp;
          slot[req.entry_index].ramp_minutes = req.ramp_minutes;
        end
      end else begin
        expected_q.push_back(lookup(req.now_time));
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual found=%0b temperature=%0d",
                 $time, got.found, got.temperature);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found mismatch: expected %0b, actual %0b",
                 $time, want.found, got.found);
        errors++;
      end
      if (got.temperature !== want.temperature) begin
        $display("%0t: temperature mismatch: expected %0d, actual %0d",
                 $time, want.temperature, got.temperature);
        errors++;
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  setpoint_scoreboard sb;
  bit no_idle     = 1'b0;
  int cycle_count = 0;
  int start_palette [6] = '{0, 60, 360, 720, 1080, 1439};

  timed_setpoint_ramp_lookup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bound the run: a hung handshake ends it here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed_setpoint_ramp_lookup_tb: errors");
      $finish;
    end
  end

  // Draw the idle gap for one request or one result; zero during busy phases.
  function automatic int idle_gap();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // Mix extremes, small values near zero and full-range noise.
  function automatic logic [15:0] rand_temp();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1:       return 16'($urandom_range(0, 6000) - 3000);
      default: return 16'($urandom());
    endcase
  endfunction

  // Build a write request; fill the query-only field with noise.
  function automatic in_t write_req(logic [3:0] idx, logic valid, logic [10:0] sm,
                                    logic ramped, logic [15:0] st, logic [15:0] et,
                                    logic [10:0] rm);
    in_t req;
    req.op           = OP_WRITE;
    req.entry_index  = idx;
    req.entry_valid  = valid;
    req.start_minute = sm;
    req.ramped       = ramped;
    req.start_temp   = st;
    req.end_temp     = et;
    req.ramp_minutes = rm;
    req.now_time     = 15'($urandom());
    return req;
  endfunction

  // Build a query request; fill the entry fields with noise, the block ignores them.
  function automatic in_t query_req(logic [14:0] now);
    in_t req;
    req          = in_t'({$urandom(), $urandom(), $urandom()});
    req.op       = OP_QUERY;
    req.now_time = now;
    return req;
  endfunction

  // Hold valid and payload until the request is taken, then note it.
  // Lower valid only when a gap follows, so valid never drops and rises in one step.
  task automatic send_request(in_t req);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  // Accept results forever, stalling ready at random before each one.
  task automatic drain_results();
    int gap;
    forever begin
      gap = idle_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  endtask

  initial begin
    int   k;
    int   t;
    logic [10:0] sm;
    logic [10:0] rm;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      drain_results();
    join_none

    // Empty table right after reset: expect not found at both ends of the clock.
    send_request(query_req(15'd0));
    send_request(query_req(15'h7fff));
    // Fixed entry at midnight with the top temperature.
    send_request(write_req(4'd0, 1'b1, 11'd0, 1'b0, 16'h1234, 16'h7fff, 11'd9));
    send_request(query_req(15'd0));
    // Full-swing ramp: hit its first instant, a fraction inside its first minute and a point deep inside it.
    send_request(write_req(4'd1, 1'b1, 11'd10, 1'b1, 16'h8000, 16'h7fff, 11'd1439));
    send_request(query_req(15'(10 * 16)));
    send_request(query_req(15'(10 * 16 + 7)));
    send_request(query_req(15'(700 * 16 + 3)));
    // Tie on start minute: the higher slot must lose to slot 1.
    send_request(write_req(4'd5, 1'b1, 11'd10, 1'b0, 16'h0, 16'h8000, 11'd0));
    send_request(query_req(15'(10 * 16 + 1)));
    // Ramp with zero length answers its end value at once.
    send_request(write_req(4'd2, 1'b1, 11'd100, 1'b1, 16'h0100, 16'd1234, 11'd0));
    send_request(query_req(15'(100 * 16 + 3)));
    // Falling ramp: last fraction before the end truncates toward zero, then the end.
    send_request(write_req(4'd3, 1'b1, 11'd200, 1'b1, 16'd0, 16'(-500), 11'd2));
    send_request(query_req(15'(200 * 16 + 31)));
    send_request(query_req(15'(200 * 16 + 32)));
    // Fixed entry carries a start value and length that must be ignored.
    send_request(write_req(4'd4, 1'b1, 11'd300, 1'b0, 16'd999, 16'hffff, 11'd5));
    send_request(query_req(15'(300 * 16)));
    // Remove it again: the query falls back to the falling ramp.
    send_request(write_req(4'd4, 1'b0, 11'd300, 1'b0, 16'd999, 16'hffff, 11'd5));
    send_request(query_req(15'(300 * 16)));
    // Times beyond a day are used as given.
    send_request(write_req(4'd15, 1'b1, 11'h7ff, 1'b1, 16'h8000, 16'h7fff, 11'h7ff));
    send_request(query_req(15'h7fff));
    send_request(query_req(15'd23039));

    for (int n = 0; n < RANDOM_COUNT; n++) begin
      // Switch between idling and back-to-back phases.
      if (n % 96 == 0) no_idle = ($urandom_range(0, 3) == 0);
      // Wipe the table once midway so not-found answers get a stretch of their own.
      if (n == RANDOM_COUNT / 2) begin
        for (int s = 0; s < TABLE_ENTRIES_DEF; s++) begin
          send_request(write_req(4'(s), 1'b0, 11'($urandom()), 1'($urandom()),
                                 rand_temp(), rand_temp(), 11'($urandom())));
        end
      end
      if ($urandom_range(0, 99) < 40) begin
        // Cluster start minutes on a few values to provoke ties.
        case ($urandom_range(0, 9))
          0, 1, 2: sm = 11'(start_palette[$urandom_range(0, 5)]);
          3:       sm = 11'($urandom_range(0, 2047));
          default: sm = 11'($urandom_range(0, 1439));
        endcase
        // Favor short ramps so queries land both inside and past them.
        case ($urandom_range(0, 9))
          0:       rm = 11'd0;
          1:       rm = 11'($urandom_range(0, 2047));
          2, 3:    rm = 11'($urandom_range(0, 1439));
          default: rm = 11'($urandom_range(1, 30));
        endcase
        send_request(write_req(4'($urandom_range(0, 15)), 1'($urandom_range(0, 4) != 0),
                               sm, 1'($urandom()), rand_temp(), rand_temp(), rm));
      end else begin
        case ($urandom_range(0, 9))
          0:          t = $urandom_range(0, 32767);
          1, 2, 3, 4: t = $urandom_range(0, 23039);
          default: begin
            // Aim just before, inside or just past a stored entry's ramp.
            k = $urandom_range(0, TABLE_ENTRIES_DEF - 1);
            t = int'(sb.slot[k].start_minute) * 16 - 8 +
                $urandom_range(0, int'(sb.slot[k].ramp_minutes) * 16 + 56);
          end
        endcase
        if (t < 0) t = 0;
        if (t > 32767) t = 32767;
        send_request(query_req(15'(t)));
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding answers, then watch for stray results.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("timed_setpoint_ramp_lookup_tb: clean");
    end else begin
      $display("timed_setpoint_ramp_lookup_tb: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tsrl_pkg.sv
rtl/tsrl_ctrl.sv
rtl/tsrl_dp.sv
rtl/timed_setpoint_ramp_lookup.sv
rtl/tsrl_chk.sv
verif/timed_setpoint_ramp_lookup_tb.sv
